// ===== src/tvr_pkg.sv =====
// Shared types, constants and helper functions for the tilt vector rotation block.
// No dependencies; the cells, the output buffer and the top level import this package.
package tvr_pkg;

  localparam int SQRT_STEPS    = 24;
  localparam int DIV_STEPS     = 23;
  localparam int CORDIC_STAGES = 24;

  localparam logic [15:0]        MAX_ANGLE_RESET = 16'd46080;
  localparam logic [26:0]        DEG2RAD_Q32     = 27'd74961321;
  localparam logic signed [25:0] PI_Q20          = 26'sd3294199;
  localparam logic signed [25:0] TWO_PI_Q20      = 26'sd6588398;
  localparam logic signed [25:0] HALF_PI_Q20     = 26'sd1647099;
  localparam logic signed [33:0] INV_GAIN_Q30    = 34'sd652032874;

  typedef logic signed [23:0] s24_t;

  typedef struct packed {
    s24_t a0;
    s24_t a1;
    s24_t vx;
    s24_t vy;
    s24_t vz;
    logic zero;
  } sq_pay_t;

  typedef struct packed {
    logic [47:0] rem;
    logic [47:0] root;
    sq_pay_t     pay;
  } sq_t;

  typedef struct packed {
    logic                zero;
    logic                clamp;
    logic                flip;
    logic signed [21:0]  theta;
    s24_t                vx;
    s24_t                vy;
    s24_t                vz;
  } rot_pay_t;

  typedef struct packed {
    logic [23:0] norm;
    logic [23:0] rem0;
    logic [23:0] rem1;
    logic [22:0] q0;
    logic [22:0] q1;
    logic        lsb0;
    logic        lsb1;
    logic        neg0;
    logic        neg1;
    rot_pay_t    pay;
  } dv_t;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    s24_t               ux;
    s24_t               uy;
    rot_pay_t           pay;
  } cor_t;

  typedef struct packed {
    s24_t rot_x;
    s24_t rot_y;
    s24_t rot_z;
    logic angle_clamped;
  } res_t;

  function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
    logic signed [33:0] r;
    unique case (i)
      5'd0:  r = 34'sd843314857;
      5'd1:  r = 34'sd497837829;
      5'd2:  r = 34'sd263043837;
      5'd3:  r = 34'sd133525159;
      5'd4:  r = 34'sd67021687;
      5'd5:  r = 34'sd33543516;
      5'd6:  r = 34'sd16775851;
      5'd7:  r = 34'sd8388437;
      5'd8:  r = 34'sd4194283;
      5'd9:  r = 34'sd2097149;
      5'd10: r = 34'sd1048576;
      5'd11: r = 34'sd524288;
      5'd12: r = 34'sd262144;
      5'd13: r = 34'sd131072;
      5'd14: r = 34'sd65536;
      5'd15: r = 34'sd32768;
      5'd16: r = 34'sd16384;
      5'd17: r = 34'sd8192;
      5'd18: r = 34'sd4096;
      5'd19: r = 34'sd2048;
      5'd20: r = 34'sd1024;
      5'd21: r = 34'sd512;
      5'd22: r = 34'sd256;
      5'd23: r = 34'sd128;
      5'd24: r = 34'sd64;
      5'd25: r = 34'sd32;
      5'd26: r = 34'sd16;
      5'd27: r = 34'sd8;
      5'd28: r = 34'sd4;
      5'd29: r = 34'sd2;
      5'd30: r = 34'sd1;
      5'd31: r = 34'sd0;
    endcase
    return r;
  endfunction

  function automatic s24_t sat24(input logic signed [39:0] v);
    s24_t r;
    if (v > 40'sd8388607) r = 24'sh7FFFFF;
    else if (v < -40'sd8388608) r = 24'sh800000;
    else r = v[23:0];
    return r;
  endfunction

endpackage

// ===== src/tvr_ifs.sv =====
// Handshake interfaces for the request, response and configuration channels.
// Standalone; payload widths follow the block's field list.
interface tvr_req_if;
  logic              valid;
  logic              ready;
  logic signed [23:0] tilt_first;
  logic signed [23:0] tilt_second;
  logic signed [23:0] dir_x;
  logic signed [23:0] dir_y;
  logic signed [23:0] dir_z;
  modport source (output valid, tilt_first, tilt_second, dir_x, dir_y, dir_z, input ready);
  modport sink (input valid, tilt_first, tilt_second, dir_x, dir_y, dir_z, output ready);
endinterface

interface tvr_rsp_if;
  logic              valid;
  logic              ready;
  logic signed [23:0] rot_x;
  logic signed [23:0] rot_y;
  logic signed [23:0] rot_z;
  logic              angle_clamped;
  modport source (output valid, rot_x, rot_y, rot_z, angle_clamped, input ready);
  modport sink (input valid, rot_x, rot_y, rot_z, angle_clamped, output ready);
endinterface

interface tvr_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] max_angle_deg;
  modport source (output valid, max_angle_deg, input ready);
  modport sink (input valid, max_angle_deg, output ready);
endinterface

// ===== src/tvr_sqrt_cell.sv =====
// One step of the digit-by-digit integer square root (two radicand bits per cell).
// Depends on tvr_pkg.
module tvr_sqrt_cell (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic [4:0]   idx,
  input  logic         in_valid,
  input  tvr_pkg::sq_t d,
  output logic         out_valid,
  output tvr_pkg::sq_t q
);
  import tvr_pkg::*;

  logic [47:0] bitv;
  logic [47:0] trial;
  sq_t         nxt;

  always_comb begin
    bitv  = 48'd1 << (6'd46 - {idx, 1'b0});
    trial = d.root + bitv;
    nxt   = d;
    if (d.rem >= trial) begin
      nxt.rem  = d.rem - trial;
      nxt.root = (d.root >> 1) + bitv;
    end else begin
      nxt.root = d.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) q <= nxt;
  end

endmodule

// ===== src/tvr_div_cell.sv =====
// One restoring-division step for both axis components (one quotient bit each).
// Depends on tvr_pkg.
module tvr_div_cell (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         first,
  input  logic         in_valid,
  input  tvr_pkg::dv_t d,
  output logic         out_valid,
  output tvr_pkg::dv_t q
);
  import tvr_pkg::*;

  logic [24:0] sh0;
  logic [24:0] sh1;
  logic [24:0] dvs;
  dv_t         nxt;

  always_comb begin
    dvs = {1'b0, d.norm};
    sh0 = {d.rem0, first & d.lsb0};
    sh1 = {d.rem1, first & d.lsb1};
    nxt = d;
    // shift in the next dividend bit, subtract when the divisor fits
    if (sh0 >= dvs) begin
      nxt.rem0 = 24'(sh0 - dvs);
      nxt.q0   = {d.q0[21:0], 1'b1};
    end else begin
      nxt.rem0 = sh0[23:0];
      nxt.q0   = {d.q0[21:0], 1'b0};
    end
    if (sh1 >= dvs) begin
      nxt.rem1 = 24'(sh1 - dvs);
      nxt.q1   = {d.q1[21:0], 1'b1};
    end else begin
      nxt.rem1 = sh1[23:0];
      nxt.q1   = {d.q1[21:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) q <= nxt;
  end

endmodule

// ===== src/tvr_cordic_cell.sv =====
// One rotation-mode CORDIC micro-rotation with a floor shift by the cell index.
// Depends on tvr_pkg.
module tvr_cordic_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic [4:0]    idx,
  input  logic          in_valid,
  input  tvr_pkg::cor_t d,
  output logic          out_valid,
  output tvr_pkg::cor_t q
);
  import tvr_pkg::*;

  logic signed [33:0] xv;
  logic signed [33:0] yv;
  logic signed [33:0] dx;
  logic signed [33:0] dy;
  logic signed [33:0] at;
  cor_t               nxt;

  always_comb begin
    xv  = d.x;
    yv  = d.y;
    dx  = yv >>> idx;
    dy  = xv >>> idx;
    at  = atan_q30(idx);
    nxt = d;
    if (!d.z[33]) begin
      nxt.x = xv - dx;
      nxt.y = yv + dy;
      nxt.z = d.z - at;
    end else begin
      nxt.x = xv + dx;
      nxt.y = yv - dy;
      nxt.z = d.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) q <= nxt;
  end

endmodule

// ===== src/tvr_out_buf.sv =====
// Two-entry result buffer that decouples the pipeline from response backpressure.
// Depends on tvr_pkg and tvr_rsp_if.
module tvr_out_buf (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tvr_pkg::res_t din,
  output logic          room,
  tvr_rsp_if.source     rsp
);
  import tvr_pkg::*;

  res_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;
  res_t       head;

  assign pop           = rsp.valid && rsp.ready;
  assign room          = (count != 2'd2);
  assign head          = mem[rd_ptr];
  assign rsp.valid     = (count != 2'd0);
  assign rsp.rot_x     = head.rot_x;
  assign rsp.rot_y     = head.rot_y;
  assign rsp.rot_z     = head.rot_z;
  assign rsp.angle_clamped = head.angle_clamped;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= din;
  end

endmodule

// ===== src/tilt_vector_rotation.sv =====
// Tilt vector rotation top level: rotates a Q1.22 vector about a horizontal axis.
// Depends on tvr_pkg, tvr_ifs, tvr_sqrt_cell, tvr_div_cell, tvr_cordic_cell, tvr_out_buf.
//
//   channel | dir | payload                                  | request taken when
//   --------+-----+------------------------------------------+---------------------
//   req     | in  | tilt_first, tilt_second, dir_x/y/z       | req.valid & req.ready
//   rsp     | out | rot_x, rot_y, rot_z, angle_clamped       | rsp.valid & rsp.ready
//   cfg     | in  | max_angle_deg                            | cfg.valid (ready tied high)
//
// One request per cycle is taken while the pipeline advances; each request passes through
// 80 pipeline registers (3 input/square stages, 24 square-root cells, 1 angle prep stage,
// 23 divider cells, 24 CORDIC cells, 5 product stages), the first loading at the accepting
// edge and the last writing its result into the output buffer.
// The whole pipeline advances together; it holds only when its last stage carries a
// result and the two-entry output buffer is full, so req.ready comes from registers.
// Synchronous reset clears all valid flags, the buffer and max_angle_deg (180 deg).
module tilt_vector_rotation (
  input  logic      clk,
  input  logic      rst,
  tvr_cfg_if.sink   cfg,
  tvr_req_if.sink   req,
  tvr_rsp_if.source rsp
);
  import tvr_pkg::*;

  // ---------------------------------------------------------------- config
  logic [15:0] max_angle;
  logic [22:0] lim;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) max_angle <= MAX_ANGLE_RESET;
    else if (cfg.valid) max_angle <= cfg.max_angle_deg;
  end

  // degrees Q8.8 to radians Q3.20, rounded
  always_ff @(posedge clk) begin
    lim <= 23'((43'(max_angle) * 43'(DEG2RAD_Q32) + 43'd524288) >> 20);
  end

  // ---------------------------------------------------------------- flow
  logic en;
  logic room;
  logic m5_v;

  // advance unless the last stage holds a result the buffer cannot take
  assign en        = !m5_v || room;
  assign req.ready = en;

  // ---------------------------------------------------------------- capture and squares
  logic    s0_v, s1_v, s2_v;
  sq_pay_t s0_pay, s1_pay;
  logic signed [47:0] sq0_c, sq1_c;
  logic signed [47:0] s1_sq0, s1_sq1;
  sq_t     s2;

  assign sq0_c = s0_pay.a0 * s0_pay.a0;
  assign sq1_c = s0_pay.a1 * s0_pay.a1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else if (en) begin
      s0_v <= req.valid;
      s1_v <= s0_v;
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_pay.a0   <= req.tilt_first;
      s0_pay.a1   <= req.tilt_second;
      s0_pay.vx   <= req.dir_x;
      s0_pay.vy   <= req.dir_y;
      s0_pay.vz   <= req.dir_z;
      s0_pay.zero <= (req.tilt_first == 24'sd0) && (req.tilt_second == 24'sd0);
      s1_pay      <= s0_pay;
      s1_sq0      <= sq0_c;
      s1_sq1      <= sq1_c;
      s2.rem      <= s1_sq0 + s1_sq1;
      s2.root     <= 48'd0;
      s2.pay      <= s1_pay;
    end
  end

  // ---------------------------------------------------------------- square root chain
  sq_t  sq   [SQRT_STEPS+1];
  logic sq_v [SQRT_STEPS+1];

  assign sq[0]   = s2;
  assign sq_v[0] = s2_v;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    tvr_sqrt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .idx       (5'(k)),
      .in_valid  (sq_v[k]),
      .d         (sq[k]),
      .out_valid (sq_v[k+1]),
      .q         (sq[k+1])
    );
  end

  // ---------------------------------------------------------------- angle prep
  // Clamp the norm, wrap into [-pi, pi], fold into [-pi/2, pi/2], set up division.
  sq_t                sq_o;
  logic [23:0]        norm;
  logic               clamp;
  logic signed [25:0] th0, th1, th2;
  logic               flip;
  logic [23:0]        abs0, abs1;
  dv_t                pr_next, pr;
  logic               pr_v;

  assign sq_o = sq[SQRT_STEPS];

  always_comb begin
    norm  = sq_o.root[23:0];
    clamp = norm > {1'b0, lim};
    th0   = clamp ? {3'b000, lim} : {2'b00, norm};
    th1   = (th0 > PI_Q20) ? th0 - TWO_PI_Q20 : th0;
    flip  = 1'b0;
    th2   = th1;
    if (th1 > HALF_PI_Q20) begin
      th2  = th1 - PI_Q20;
      flip = 1'b1;
    end else if (th1 < -HALF_PI_Q20) begin
      th2  = th1 + PI_Q20;
      flip = 1'b1;
    end
    abs0 = sq_o.pay.a0[23] ? 24'(-sq_o.pay.a0) : 24'(sq_o.pay.a0);
    abs1 = sq_o.pay.a1[23] ? 24'(-sq_o.pay.a1) : 24'(sq_o.pay.a1);

    pr_next.norm      = norm;
    pr_next.rem0      = {1'b0, abs0[23:1]};
    pr_next.rem1      = {1'b0, abs1[23:1]};
    pr_next.q0        = 23'd0;
    pr_next.q1        = 23'd0;
    pr_next.lsb0      = abs0[0];
    pr_next.lsb1      = abs1[0];
    pr_next.neg0      = sq_o.pay.a0[23];
    // y axis component carries the opposite sign of the second tilt
    pr_next.neg1      = !sq_o.pay.a1[23] && (sq_o.pay.a1 != 24'sd0);
    pr_next.pay.zero  = sq_o.pay.zero;
    pr_next.pay.clamp = clamp;
    pr_next.pay.flip  = flip;
    pr_next.pay.theta = th2[21:0];
    pr_next.pay.vx    = sq_o.pay.vx;
    pr_next.pay.vy    = sq_o.pay.vy;
    pr_next.pay.vz    = sq_o.pay.vz;
  end

  always_ff @(posedge clk) begin
    if (rst) pr_v <= 1'b0;
    else if (en) pr_v <= sq_v[SQRT_STEPS];
  end

  always_ff @(posedge clk) begin
    if (en) pr <= pr_next;
  end

  // ---------------------------------------------------------------- axis division chain
  dv_t  dv   [DIV_STEPS+1];
  logic dv_v [DIV_STEPS+1];

  assign dv[0]   = pr;
  assign dv_v[0] = pr_v;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    tvr_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .first     (k == 0),
      .in_valid  (dv_v[k]),
      .d         (dv[k]),
      .out_valid (dv_v[k+1]),
      .q         (dv[k+1])
    );
  end

  // ---------------------------------------------------------------- CORDIC chain
  dv_t   dv_o;
  s24_t  qm0, qm1;
  cor_t  cor_in;
  cor_t  cor   [CORDIC_STAGES+1];
  logic  cor_v [CORDIC_STAGES+1];

  assign dv_o = dv[DIV_STEPS];
  assign qm0  = {1'b0, dv_o.q0};
  assign qm1  = {1'b0, dv_o.q1};

  always_comb begin
    cor_in.x   = INV_GAIN_Q30;
    cor_in.y   = 34'sd0;
    cor_in.z   = {{2{dv_o.pay.theta[21]}}, dv_o.pay.theta, 10'd0};
    cor_in.ux  = dv_o.neg0 ? -qm0 : qm0;
    cor_in.uy  = dv_o.neg1 ? -qm1 : qm1;
    cor_in.pay = dv_o.pay;
  end

  assign cor[0]   = cor_in;
  assign cor_v[0] = dv_v[DIV_STEPS];

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
    tvr_cordic_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .idx       (5'(k)),
      .in_valid  (cor_v[k]),
      .d         (cor[k]),
      .out_valid (cor_v[k+1]),
      .q         (cor[k+1])
    );
  end

  // ---------------------------------------------------------------- products
  cor_t               co;
  s24_t               ux_c, uy_c, vx_c, vy_c;
  logic signed [33:0] c_c, s_c;
  logic               m1_v, m2_v, m3_v, m4_v;
  rot_pay_t           m1_pay, m2_pay, m3_pay, m4_pay, m5_pay;
  s24_t               m1_ux, m1_uy, m2_ux, m2_uy, m3_ux, m3_uy, m4_ux, m4_uy;
  logic signed [47:0] m1_uxvx, m1_uyvy, m1_uyvx, m1_uxvy;
  logic signed [33:0] m1_c, m1_s, m2_c, m2_s;
  logic signed [26:0] m2_p, m2_q, m3_p, m4_p;
  logic signed [60:0] m3_qc, m3_vs, m3_qs, m3_vc;
  logic signed [31:0] m4_q2, m4_r2, m5_r2;
  logic signed [55:0] m5_pux, m5_q2uy, m5_puy, m5_q2ux;
  logic signed [34:0] rx_c, ry_c;
  res_t               res;

  assign co   = cor[CORDIC_STAGES];
  assign ux_c = co.ux;
  assign uy_c = co.uy;
  assign vx_c = co.pay.vx;
  assign vy_c = co.pay.vy;
  // undo the half-turn fold
  assign c_c  = co.pay.flip ? -co.x : co.x;
  assign s_c  = co.pay.flip ? -co.y : co.y;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_v <= 1'b0;
      m2_v <= 1'b0;
      m3_v <= 1'b0;
      m4_v <= 1'b0;
      m5_v <= 1'b0;
    end else if (en) begin
      m1_v <= cor_v[CORDIC_STAGES];
      m2_v <= m1_v;
      m3_v <= m2_v;
      m4_v <= m3_v;
      m5_v <= m4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // project onto the axis and its horizontal normal
      m1_uxvx <= ux_c * vx_c;
      m1_uyvy <= uy_c * vy_c;
      m1_uyvx <= uy_c * vx_c;
      m1_uxvy <= ux_c * vy_c;
      m1_c    <= c_c;
      m1_s    <= s_c;
      m1_ux   <= ux_c;
      m1_uy   <= uy_c;
      m1_pay  <= co.pay;

      m2_p   <= 27'((49'(m1_uxvx) + 49'(m1_uyvy) + 49'sd2097152) >>> 22);
      m2_q   <= 27'((49'(m1_uxvy) - 49'(m1_uyvx) + 49'sd2097152) >>> 22);
      m2_c   <= m1_c;
      m2_s   <= m1_s;
      m2_ux  <= m1_ux;
      m2_uy  <= m1_uy;
      m2_pay <= m1_pay;

      // rotate the (normal, vertical) pair
      m3_qc  <= m2_q * m2_c;
      m3_vs  <= m2_pay.vz * m2_s;
      m3_qs  <= m2_q * m2_s;
      m3_vc  <= m2_pay.vz * m2_c;
      m3_p   <= m2_p;
      m3_ux  <= m2_ux;
      m3_uy  <= m2_uy;
      m3_pay <= m2_pay;

      m4_q2  <= 32'((62'(m3_qc) - 62'(m3_vs) + 62'sd536870912) >>> 30);
      m4_r2  <= 32'((62'(m3_qs) + 62'(m3_vc) + 62'sd536870912) >>> 30);
      m4_p   <= m3_p;
      m4_ux  <= m3_ux;
      m4_uy  <= m3_uy;
      m4_pay <= m3_pay;

      // project back onto x and y
      m5_pux  <= m4_p * m4_ux;
      m5_q2uy <= m4_q2 * m4_uy;
      m5_puy  <= m4_p * m4_uy;
      m5_q2ux <= m4_q2 * m4_ux;
      m5_r2   <= m4_r2;
      m5_pay  <= m4_pay;
    end
  end

  assign rx_c = 35'((57'(m5_pux) - 57'(m5_q2uy) + 57'sd2097152) >>> 22);
  assign ry_c = 35'((57'(m5_puy) + 57'(m5_q2ux) + 57'sd2097152) >>> 22);

  // zero tilt passes the vector through untouched
  always_comb begin
    if (m5_pay.zero) begin
      res.rot_x         = m5_pay.vx;
      res.rot_y         = m5_pay.vy;
      res.rot_z         = m5_pay.vz;
      res.angle_clamped = 1'b0;
    end else begin
      res.rot_x         = sat24(40'(rx_c));
      res.rot_y         = sat24(40'(ry_c));
      res.rot_z         = sat24(40'(m5_r2));
      res.angle_clamped = m5_pay.clamp;
    end
  end

  // ---------------------------------------------------------------- output buffer
  tvr_out_buf u_out_buf (
    .clk  (clk),
    .rst  (rst),
    .push (m5_v && en),
    .din  (res),
    .room (room),
    .rsp  (rsp)
  );

endmodule

// ===== src/tvr_checker.sv =====
// Port-level checks on the tilt vector rotation top level, bound to it below.
// Depends only on the top level's ports.
module tvr_checker (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic signed [23:0] rot_x,
  input logic signed [23:0] rot_y,
  input logic signed [23:0] rot_z,
  input logic              angle_clamped
);

  // hold a stalled response
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rot_x) && $stable(rot_y) && $stable(rot_z)
      && $stable(angle_clamped))
    else $error("response payload changed while stalled");

  // drop all pending results on reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid right after reset");

  // requests stall only when the output buffer is holding results
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_ready |-> rsp_valid)
    else $error("request stalled with no response pending");

endmodule

bind tilt_vector_rotation tvr_checker u_tvr_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rot_x         (rsp.rot_x),
  .rot_y         (rsp.rot_y),
  .rot_z         (rsp.rot_z),
  .angle_clamped (rsp.angle_clamped)
);
